// ===== rtl/spde_pkg.sv =====
package spde_pkg;

    // Framing constants
    localparam logic [7:0] START_BYTE    = 8'h00;
    localparam logic [7:0] HEADER_BYTES  = 8'd3;
    localparam logic [7:0] ECHO_TYPE_RST = 8'hFE;

    // Default payload buffer depth (1 to 255)
    localparam int DEPTH_DEFAULT = 64;

endpackage

// ===== rtl/serial_packet_deframer_echo.sv =====
// Receive: one byte beat per cycle; s_tready is high whenever no echo burst is being read.
// Echo: the first byte shows on m_tdata via the state, read and output registers, then 1 byte
// per cycle at full m_tready. The rate is set by the single read port of the payload memory.
// A frame of N payload bytes is N + 3 input bytes, and its echo is N bytes.
// Reset (aresetn low, synchronous): idle, echo type 0xFE, output empty, memory unchanged.
module serial_packet_deframer_echo #(
    parameter int BUFFER_DEPTH = spde_pkg::DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    // config write channel: echo_type [7:0]
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    // s_tdata: rx_byte [7:0]
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    // m_tdata: tx_byte [7:0]; m_tlast: last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);
    import spde_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int LW = $clog2(BUFFER_DEPTH + 1);
    localparam int CW = AW + 1;
    localparam logic [7:0] DEPTH_BYTE = 8'(BUFFER_DEPTH);

    // Frame phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    // Block states
    localparam logic ST_RX   = 1'b0;
    localparam logic ST_ECHO = 1'b1;

    logic          st_reg, st_next;
    logic [1:0]    phase_reg, phase_next;
    logic [7:0]    kind_reg, kind_next;
    logic [LW-1:0] len_reg, len_next;
    logic [AW-1:0] wpos_reg, wpos_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [7:0]    echo_type_reg;

    logic          q_valid_reg, q_valid_next;
    logic          q_last_reg;
    logic [7:0]    mem_q;

    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_data_reg;
    logic          m_last_reg;

    logic [7:0]    mem [BUFFER_DEPTH];

    logic          s_beat;
    logic          wr_en;
    logic          rd_en;
    logic          rd_last;
    logic          out_free;
    logic          q_move;
    logic [7:0]    len_byte;
    logic          len_bad;
    logic          more_data;

    assign cfg_ready = 1'b1;
    assign s_tready  = (st_reg == ST_RX);
    assign s_beat    = s_tvalid && s_tready;

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;

    // Length checks: payload length is the length byte minus the header
    assign len_byte  = s_tdata - HEADER_BYTES;
    assign len_bad   = (s_tdata < HEADER_BYTES) || (len_byte > DEPTH_BYTE);
    assign more_data = (CW'(wpos_reg) + CW'(1)) < CW'(len_reg);

    // Echo read sequencing: move the read word to the output, then refill
    assign out_free = !m_valid_reg || m_tready;
    assign q_move   = q_valid_reg && out_free;
    assign rd_en    = (st_reg == ST_ECHO) && (!q_valid_reg || q_move);
    assign rd_last  = (CW'(rd_ptr_reg) + CW'(1)) == CW'(len_reg);
    assign wr_en    = s_beat && (s_tdata != START_BYTE) && (phase_reg == PH_DATA);

    // Frame parser and echo control
    always_comb begin
        st_next      = st_reg;
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        len_next     = len_reg;
        wpos_next    = wpos_reg;
        rd_ptr_next  = rd_ptr_reg;
        q_valid_next = q_valid_reg;
        m_valid_next = m_valid_reg;

        if (s_beat) begin
            if (s_tdata == START_BYTE) begin
                phase_next = PH_TYPE;
            end else begin
                case (phase_reg)
                    PH_TYPE: begin
                        kind_next  = s_tdata;
                        phase_next = PH_LEN;
                    end
                    PH_LEN: begin
                        if (len_bad) begin
                            phase_next = PH_IDLE;
                        end else begin
                            len_next   = len_byte[LW-1:0];
                            wpos_next  = '0;
                            phase_next = (len_byte == 8'd0) ? PH_IDLE : PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        if (more_data) begin
                            wpos_next = wpos_reg + AW'(1);
                        end else begin
                            phase_next = PH_IDLE;
                            if (kind_reg == echo_type_reg) begin
                                st_next     = ST_ECHO;
                                rd_ptr_next = '0;
                            end
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        // Drain the output register
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (q_move) begin
            m_valid_next = 1'b1;
            q_valid_next = 1'b0;
        end

        // Issue the next read of the burst
        if (rd_en) begin
            q_valid_next = 1'b1;
            rd_ptr_next  = rd_ptr_reg + AW'(1);
            if (rd_last) begin
                st_next = ST_RX;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_RX;
            phase_reg     <= PH_IDLE;
            kind_reg      <= '0;
            len_reg       <= '0;
            wpos_reg      <= '0;
            rd_ptr_reg    <= '0;
            q_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            echo_type_reg <= ECHO_TYPE_RST;
        end else begin
            st_reg      <= st_next;
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            len_reg     <= len_next;
            wpos_reg    <= wpos_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_valid_reg <= q_valid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                echo_type_reg <= cfg_data;
            end
        end
    end

    // Payload memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wpos_reg] <= s_tdata;
        end
        if (rd_en) begin
            mem_q      <= mem[rd_ptr_reg];
            q_last_reg <= rd_last;
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        if (q_move) begin
            m_data_reg <= mem_q;
            m_last_reg <= q_last_reg;
        end
    end

endmodule
